// ===== hw/rtl/mlr_pkg.sv =====
// ----------------------------------------------------------------------------
// mlr_pkg: shared types and constants of the matrix line rotator
// Item layouts, action and register codes, default sizes, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mlr_pkg;

  // Default sizes
  localparam int MAX_DIM_DEF    = 32;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int ACTION_W   = 2;
  localparam int IDX_W      = 5;
  localparam int VALUE_W    = 32;
  localparam int AMOUNT_W   = 16;
  localparam int DIM_CFG_W  = 6;
  localparam int CFG_IDX_W  = 1;

  localparam logic [DIM_CFG_W-1:0] DIM_RESET = 6'd32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

  // Actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE   = 2'd0,
    ACT_READ    = 2'd1,
    ACT_ROT_ROW = 2'd2,
    ACT_ROT_COL = 2'd3
  } action_e;

  // Input item
  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [VALUE_W-1:0] write_value;
    logic                     shift_left;
    logic [AMOUNT_W-1:0]      amount;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic                      status;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;   // latch accepted item
    logic set_result;  // preset result: status from range check, value zero
    logic elem_write;  // single element write
    logic elem_read;   // single element read
    logic cap_read;    // take read data into result
    logic mod_start;   // start amount mod length
    logic line_init;   // load source and destination indexes
    logic rd_step;     // one element of the gather pass
    logic clr_idx;     // rewind destination index
    logic wr_step;     // one element of the write-back pass
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic    err;
    action_e action;
    logic    mod_done;
    logic    last;
  } dp_status_t;

endpackage

// ===== hw/rtl/mlr_mod.sv =====
// ----------------------------------------------------------------------------
// mlr_mod: iterative remainder unit
// Restoring division, one dividend bit per cycle; gives amount mod length.
// ----------------------------------------------------------------------------
module mlr_mod #(
  parameter int DIM_W = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mlr_pkg::AMOUNT_W-1:0]  dividend_i,
  input  logic [DIM_W-1:0]              divisor_i,
  output logic                          done_o,
  output logic [DIM_W-1:0]              rem_o
);

  localparam int CntW = $clog2(mlr_pkg::AMOUNT_W + 1);

  logic [mlr_pkg::AMOUNT_W-1:0] dvd_q;
  logic [DIM_W-1:0]             div_q;
  logic [DIM_W-1:0]             rem_q;
  logic [CntW-1:0]              cnt_q;
  logic                         run_q;
  logic [DIM_W:0]               trial;
  logic [DIM_W:0]               diff;

  // one restoring step
  assign trial = {rem_q, dvd_q[mlr_pkg::AMOUNT_W-1]};
  assign diff  = trial - {1'b0, div_q};

  assign done_o = run_q && (cnt_q == '0);
  assign rem_o  = rem_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= CntW'(mlr_pkg::AMOUNT_W);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q && (cnt_q != '0)) begin
      dvd_q <= {dvd_q[mlr_pkg::AMOUNT_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_q <= DIM_W'(diff);
      end else begin
        rem_q <= DIM_W'(trial);
      end
    end
  end

endmodule

// ===== hw/rtl/mlr_datapath.sv =====
// ----------------------------------------------------------------------------
// mlr_datapath: matrix store, line buffer and index logic
// Holds the dimension registers, the element store, the rotation scratch
// line, the index counters and the result register.
// ----------------------------------------------------------------------------
module mlr_datapath #(
  parameter int MAX_DIM    = mlr_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = mlr_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mlr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mlr_pkg::DIM_CFG_W-1:0]  cfg_data_i,
  input  mlr_pkg::in_item_t              item_i,
  input  mlr_pkg::ctrl_cmd_t             cmd_i,
  output mlr_pkg::dp_status_t            status_o,
  output mlr_pkg::out_item_t             result_o
);

  localparam int IdxW  = $clog2(MAX_DIM);
  localparam int DimW  = $clog2(MAX_DIM + 1);
  localparam int AddrW = 2 * IdxW;
  localparam int Depth = 2 ** AddrW;

  // Dimension registers
  logic [mlr_pkg::DIM_CFG_W-1:0] rows_cfg_q;
  logic [mlr_pkg::DIM_CFG_W-1:0] cols_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= mlr_pkg::DIM_RESET;
      cols_cfg_q <= mlr_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mlr_pkg::CFG_NUM_ROWS: rows_cfg_q <= cfg_data_i;
        mlr_pkg::CFG_NUM_COLS: cols_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero counts as one, anything past the store size as the store size
  function automatic logic [DimW-1:0] clamp_dim(logic [mlr_pkg::DIM_CFG_W-1:0] v);
    if (v == '0) begin
      return DimW'(1);
    end else if (8'(v) > 8'(MAX_DIM)) begin
      return DimW'(MAX_DIM);
    end else begin
      return DimW'(v);
    end
  endfunction

  logic [DimW-1:0] rows;
  logic [DimW-1:0] cols;
  assign rows = clamp_dim(rows_cfg_q);
  assign cols = clamp_dim(cols_cfg_q);

  // Latched item
  mlr_pkg::in_item_t item_q;
  mlr_pkg::action_e  action;
  logic              is_row;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= item_i;
    end
  end

  assign action = mlr_pkg::action_e'(item_q.action);
  assign is_row = (action == mlr_pkg::ACT_ROT_ROW);

  // Range check
  logic row_bad;
  logic col_bad;
  logic err;

  assign row_bad = 8'(item_q.row_index) >= 8'(rows);
  assign col_bad = 8'(item_q.col_index) >= 8'(cols);

  always_comb begin
    case (action)
      mlr_pkg::ACT_ROT_ROW: err = row_bad;
      mlr_pkg::ACT_ROT_COL: err = col_bad;
      default:              err = row_bad | col_bad;
    endcase
  end

  // Line length and amount reduction
  logic [DimW-1:0] len;
  logic            mod_done;
  logic [DimW-1:0] k;

  assign len = is_row ? cols : rows;

  mlr_mod #(
    .DIM_W (DimW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (item_q.amount),
    .divisor_i  (len),
    .done_o     (mod_done),
    .rem_o      (k)
  );

  // Source and destination indexes
  logic [IdxW-1:0] src_q;
  logic [IdxW-1:0] j_q;
  logic [IdxW-1:0] src_start;
  logic            src_wrap;
  logic            last;

  // left: first source is k; right: first source is len - k (zero stays zero)
  always_comb begin
    if (item_q.shift_left || (k == '0)) begin
      src_start = IdxW'(k);
    end else begin
      src_start = IdxW'(len - k);
    end
  end

  assign src_wrap = (DimW'(src_q) == len - DimW'(1));
  assign last     = (DimW'(j_q) == len - DimW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= '0;
      j_q   <= '0;
    end else begin
      if (cmd_i.line_init || cmd_i.clr_idx) begin
        j_q <= '0;
      end else if (cmd_i.rd_step || cmd_i.wr_step) begin
        j_q <= j_q + IdxW'(1);
      end
      if (cmd_i.line_init) begin
        src_q <= src_start;
      end else if (cmd_i.rd_step) begin
        src_q <= src_wrap ? '0 : src_q + IdxW'(1);
      end
    end
  end

  // Store address of element idx of the selected line
  function automatic logic [AddrW-1:0] line_addr(logic row_line, logic [IdxW-1:0] fix_row,
                                                 logic [IdxW-1:0] fix_col,
                                                 logic [IdxW-1:0] idx);
    if (row_line) begin
      return {fix_row, idx};
    end else begin
      return {idx, fix_col};
    end
  endfunction

  logic [IdxW-1:0] row_i;
  logic [IdxW-1:0] col_i;
  assign row_i = IdxW'(item_q.row_index);
  assign col_i = IdxW'(item_q.col_index);

  // Pass pipelines: each memory read is written to the other memory in the cycle after
  logic            lb_wr_pend_q;
  logic [IdxW-1:0] lb_widx_q;
  logic            st_wr_pend_q;
  logic [IdxW-1:0] st_widx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lb_wr_pend_q <= 1'b0;
      st_wr_pend_q <= 1'b0;
      lb_widx_q    <= '0;
      st_widx_q    <= '0;
    end else begin
      lb_wr_pend_q <= cmd_i.rd_step;
      st_wr_pend_q <= cmd_i.wr_step;
      lb_widx_q    <= j_q;
      st_widx_q    <= j_q;
    end
  end

  // Element store
  logic [DATA_WIDTH-1:0] store_mem [Depth];
  logic [DATA_WIDTH-1:0] st_rdata_q;
  logic                  st_we;
  logic [AddrW-1:0]      st_waddr;
  logic [DATA_WIDTH-1:0] st_wdata;
  logic                  st_re;
  logic [AddrW-1:0]      st_raddr;
  logic [DATA_WIDTH-1:0] lb_rdata_q;

  assign st_we    = cmd_i.elem_write | st_wr_pend_q;
  assign st_waddr = cmd_i.elem_write ? {row_i, col_i}
                                     : line_addr(is_row, row_i, col_i, st_widx_q);
  assign st_wdata = cmd_i.elem_write ? DATA_WIDTH'(item_q.write_value) : lb_rdata_q;
  assign st_re    = cmd_i.elem_read | cmd_i.rd_step;
  assign st_raddr = cmd_i.elem_read ? {row_i, col_i}
                                    : line_addr(is_row, row_i, col_i, src_q);

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_q <= store_mem[st_raddr];
    end
  end

  // Line buffer
  logic [DATA_WIDTH-1:0] line_mem [MAX_DIM];

  always_ff @(posedge clk_i) begin
    if (lb_wr_pend_q) begin
      line_mem[lb_widx_q] <= st_rdata_q;
    end
    if (cmd_i.wr_step) begin
      lb_rdata_q <= line_mem[j_q];
    end
  end

  // Result register
  mlr_pkg::out_item_t result_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_result) begin
      result_q.status     <= err;
      result_q.read_value <= '0;
    end else if (cmd_i.cap_read) begin
      result_q.read_value <= mlr_pkg::VALUE_W'($signed(st_rdata_q));
    end
  end

  assign result_o = result_q;

  assign status_o.err      = err;
  assign status_o.action   = action;
  assign status_o.mod_done = mod_done;
  assign status_o.last     = last;

endmodule

// ===== hw/rtl/mlr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlr_ctrl: sequencing state machine
// Decodes the latched item and steps the datapath through an access or
// through the reduce, gather and write-back passes of a rotation.
// ----------------------------------------------------------------------------
module mlr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  mlr_pkg::dp_status_t  status_i,
  output mlr_pkg::ctrl_cmd_t   cmd_o,
  output logic                 result_valid_o
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECODE  = 9'b000000010,
    S_RDWAIT  = 9'b000000100,
    S_MOD     = 9'b000001000,
    S_RDPASS  = 9'b000010000,
    S_RDDRAIN = 9'b000100000,
    S_WRPASS  = 9'b001000000,
    S_WRDRAIN = 9'b010000000,
    S_RESP    = 9'b100000000
  } state_e;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.set_result = 1'b1;
        if (status_i.err) begin
          state_d = S_RESP;
        end else begin
          unique case (status_i.action)
            mlr_pkg::ACT_WRITE: begin
              cmd_o.elem_write = 1'b1;
              state_d          = S_RESP;
            end
            mlr_pkg::ACT_READ: begin
              cmd_o.elem_read = 1'b1;
              state_d         = S_RDWAIT;
            end
            default: begin
              cmd_o.mod_start = 1'b1;
              state_d         = S_MOD;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        cmd_o.cap_read = 1'b1;
        state_d        = S_RESP;
      end
      S_MOD: begin
        if (status_i.mod_done) begin
          cmd_o.line_init = 1'b1;
          state_d         = S_RDPASS;
        end
      end
      S_RDPASS: begin
        cmd_o.rd_step = 1'b1;
        if (status_i.last) begin
          state_d = S_RDDRAIN;
        end
      end
      S_RDDRAIN: begin
        // last gathered element lands in the line buffer here
        cmd_o.clr_idx = 1'b1;
        state_d       = S_WRPASS;
      end
      S_WRPASS: begin
        cmd_o.wr_step = 1'b1;
        if (status_i.last) begin
          state_d = S_WRDRAIN;
        end
      end
      S_WRDRAIN: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_RESP);

endmodule

// ===== hw/rtl/matrix_line_rotator.sv =====
// ----------------------------------------------------------------------------
// matrix_line_rotator: matrix store with cyclic row and column rotation
// Writes, reads and rotates elements of a MAX_DIM by MAX_DIM store of
// signed words, of which the configured rows and columns are in use.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// its one result has been shown. The result is on result_o for exactly one
// cycle with result_valid_o high and must be taken then: there is no way to
// hold it off. A write, or any item with an index outside the dimensions in
// use, goes from the decode state straight to the result state; a read first
// passes a read-wait state. A rotation of a line of L elements passes one
// decode state, the bit-serial remainder unit that reduces the amount modulo
// L, then one pass that gathers the line into a scratch buffer and one that
// writes it back, one element per cycle each and each followed by a drain
// state, through the single write port of the store, and the result state.
// The next item can be taken in the cycle after any result.
// The dimension registers are written over a valid/ready channel that
// is always ready; write them only while busy is low.
module matrix_line_rotator #(
  parameter int MAX_DIM    = mlr_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = mlr_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  mlr_pkg::in_item_t              item_i,
  output logic                           result_valid_o,
  output mlr_pkg::out_item_t             result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mlr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mlr_pkg::DIM_CFG_W-1:0]  cfg_data_i
);

  mlr_pkg::ctrl_cmd_t  cmd;
  mlr_pkg::dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  mlr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .status_i       (dp_status),
    .cmd_o          (cmd),
    .result_valid_o (result_valid_o)
  );

  mlr_datapath #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .result_o    (result_o)
  );

endmodule

// ===== bench/matrix_line_rotator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_line_rotator_checker: result predictor and comparator
// Watches the command, result and dimension channels of the matrix line
// rotator. It keeps its own copy of the matrix and the dimensions, predicts
// the result of every accepted item, and compares each result in order.
// ----------------------------------------------------------------------------
module matrix_line_rotator_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  mlr_pkg::in_item_t             item_i,
  input  logic                          result_valid_i,
  input  mlr_pkg::out_item_t            result_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [mlr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mlr_pkg::DIM_CFG_W-1:0] cfg_data_i,
  output int                            fail_count_o,
  output int                            outstanding_o
);
  import mlr_pkg::*;

  localparam int  SIDE           = MAX_DIM_DEF;
  localparam int  REPORT_LIMIT   = 40;
  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_OUT_OF_RANGE = 1'b1;

  // Mirror of the matrix and of the dimension registers
  logic [VALUE_W-1:0]   elem_store [SIDE*SIDE];
  logic [DIM_CFG_W-1:0] rows_cfg;
  logic [DIM_CFG_W-1:0] cols_cfg;
  out_item_t            pending_results [$];

  // Register value as used by the block: zero means one, large means full size
  function automatic int unsigned dim_in_use(logic [DIM_CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > SIDE) return SIDE;
    return v;
  endfunction

  // Cyclic shift of one row or column, gathered first and then written back
  function automatic void rotate_line(bit along_row, int unsigned fixed, int unsigned len,
                                      bit left, int unsigned amt);
    logic [VALUE_W-1:0] line_copy [SIDE];
    int unsigned j, k, src;
    k = amt % len;
    for (j = 0; j < len; j++) begin
      src = left ? (j + k) % len : (j + len - k) % len;
      line_copy[j] = along_row ? elem_store[fixed*SIDE + src] : elem_store[src*SIDE + fixed];
    end
    for (j = 0; j < len; j++) begin
      if (along_row) elem_store[fixed*SIDE + j] = line_copy[j];
      else elem_store[j*SIDE + fixed] = line_copy[j];
    end
  endfunction

  // Applies one command to the mirror and returns the result it gives
  function automatic out_item_t apply_command(in_item_t cmd);
    out_item_t   res;
    int unsigned rows, cols, r, c;
    rows = dim_in_use(rows_cfg);
    cols = dim_in_use(cols_cfg);
    r = cmd.row_index;
    c = cmd.col_index;
    res.read_value = '0;
    res.status = STATUS_DONE;
    case (cmd.action)
      ACT_WRITE: begin
        if (r >= rows || c >= cols) res.status = STATUS_OUT_OF_RANGE;
        else elem_store[r*SIDE + c] = cmd.write_value;
      end
      ACT_READ: begin
        if (r >= rows || c >= cols) res.status = STATUS_OUT_OF_RANGE;
        else res.read_value = elem_store[r*SIDE + c];
      end
      ACT_ROT_ROW: begin
        if (r >= rows) res.status = STATUS_OUT_OF_RANGE;
        else rotate_line(1'b1, r, cols, cmd.shift_left, cmd.amount);
      end
      default: begin
        if (c >= cols) res.status = STATUS_OUT_OF_RANGE;
        else rotate_line(1'b0, c, rows, cmd.shift_left, cmd.amount);
      end
    endcase
    return res;
  endfunction

  // Compare results first, then take register writes and new items
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      rows_cfg = DIM_RESET;
      cols_cfg = DIM_RESET;
      pending_results.delete();
      fail_count_o = 0;
      outstanding_o = 0;
    end else begin
      if (result_valid_i) begin
        if (pending_results.size() == 0) begin
          if (fail_count_o < REPORT_LIMIT)
            $display("%0t: result with none expected, got read_value %0d status %0d",
                     $time, result_i.read_value, result_i.status);
          fail_count_o++;
        end else begin
          want = pending_results.pop_front();
          if (result_i.read_value !== want.read_value) begin
            if (fail_count_o < REPORT_LIMIT)
              $display("%0t: read_value mismatch, expected %0d, got %0d",
                       $time, want.read_value, result_i.read_value);
            fail_count_o++;
          end
          if (result_i.status !== want.status) begin
            if (fail_count_o < REPORT_LIMIT)
              $display("%0t: status mismatch, expected %0d, got %0d",
                       $time, want.status, result_i.status);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_NUM_ROWS) rows_cfg = cfg_data_i;
        else cols_cfg = cfg_data_i;
      end
      if (start_i && !busy_i) pending_results.push_back(apply_command(item_i));
      outstanding_o = pending_results.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the matrix line rotator
// Drives directed and random write, read and rotate items in bursts under
// several matrix dimensions, keeps reads on elements that hold written data,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  import mlr_pkg::*;

  localparam int SIDE            = MAX_DIM_DEF;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_PHASES      = 8;
  localparam int SETTLE_CYCLES   = 100;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             item;
  logic                 result_valid;
  out_item_t            result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_CFG_W-1:0] cfg_data;
  int                   fail_count;
  int                   outstanding;
  int                   cycle_count;

  // Stimulus-side bookkeeping: which elements hold written data
  bit          cell_written [SIDE][SIDE];
  int unsigned rows_used;
  int unsigned cols_used;
  int unsigned burst_left;

  matrix_line_rotator DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .item_i         (item),
    .result_valid_o (result_valid),
    .result_o       (result),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  matrix_line_rotator_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (item),
    .result_valid_i (result_valid),
    .result_i       (result),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("matrix_line_rotator verification failed");
      $finish;
    end
  end

  function automatic int unsigned dim_in_use(logic [DIM_CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > SIDE) return SIDE;
    return v;
  endfunction

  // Written flags move with the data when a line rotates
  function automatic void rotate_flags(bit along_row, int unsigned fixed, int unsigned len,
                                       bit left, int unsigned amt);
    bit          line_copy [SIDE];
    int unsigned j, k, src;
    k = amt % len;
    for (j = 0; j < len; j++) begin
      src = left ? (j + k) % len : (j + len - k) % len;
      line_copy[j] = along_row ? cell_written[fixed][src] : cell_written[src][fixed];
    end
    for (j = 0; j < len; j++) begin
      if (along_row) cell_written[fixed][j] = line_copy[j];
      else cell_written[j][fixed] = line_copy[j];
    end
  endfunction

  // Sends one item, in bursts with random gaps; called at a falling edge
  task automatic issue(input action_e act, input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                       input logic [VALUE_W-1:0] value, input bit left,
                       input logic [AMOUNT_W-1:0] amt);
    in_item_t    cmd;
    int unsigned gap;
    cmd.action      = act;
    cmd.row_index   = r;
    cmd.col_index   = c;
    cmd.write_value = value;
    cmd.shift_left  = left;
    cmd.amount      = amt;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    item  <= cmd;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    case (act)
      ACT_WRITE:   if (r < rows_used && c < cols_used) cell_written[r][c] = 1'b1;
      ACT_ROT_ROW: if (r < rows_used) rotate_flags(1'b1, r, cols_used, left, amt);
      ACT_ROT_COL: if (c < cols_used) rotate_flags(1'b0, c, rows_used, left, amt);
      default: ;
    endcase
  endtask

  // Stops sending and waits until every expected result has come
  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    while (outstanding != 0 || busy !== 1'b0) @(negedge clk);
  endtask

  // Both dimension registers, written only while the block is idle
  task automatic set_dims(input logic [DIM_CFG_W-1:0] rows_val,
                          input logic [DIM_CFG_W-1:0] cols_val);
    wait_idle();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_NUM_ROWS;
    cfg_data  <= rows_val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_index <= CFG_NUM_COLS;
    cfg_data  <= cols_val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
    rows_used = dim_in_use(rows_val);
    cols_used = dim_in_use(cols_val);
  endtask

  task automatic random_item();
    action_e              act;
    logic [IDX_W-1:0]     r, c;
    logic [AMOUNT_W-1:0]  amt;
    int unsigned          roll, len, tries;
    roll = $urandom_range(0, 9);
    if (roll < 3) act = ACT_WRITE;
    else if (roll < 6) act = ACT_READ;
    else if (roll < 8) act = ACT_ROT_ROW;
    else act = ACT_ROT_COL;
    // mostly inside the dimensions in use, now and then anywhere
    if ($urandom_range(0, 7) == 0) begin
      r = $urandom_range(0, SIDE - 1);
      c = $urandom_range(0, SIDE - 1);
    end else begin
      r = $urandom_range(0, rows_used - 1);
      c = $urandom_range(0, cols_used - 1);
    end
    // reads only land on elements that hold written data
    if (act == ACT_READ && r < rows_used && c < cols_used) begin
      tries = 0;
      while (!cell_written[r][c] && tries < 16) begin
        r = $urandom_range(0, rows_used - 1);
        c = $urandom_range(0, cols_used - 1);
        tries++;
      end
      if (!cell_written[r][c]) act = ACT_WRITE;
    end
    len = (act == ACT_ROT_COL) ? rows_used : cols_used;
    case ($urandom_range(0, 4))
      0:       amt = '0;
      1:       amt = AMOUNT_W'(len * $urandom_range(1, 4));
      2:       amt = AMOUNT_W'($urandom_range(1, 2 * len));
      default: amt = AMOUNT_W'($urandom());
    endcase
    issue(act, r, c, $urandom(), 1'($urandom_range(0, 1)), amt);
  endtask

  initial begin
    logic [DIM_CFG_W-1:0] rows_val, cols_val;
    rst_n      = 1'b0;
    start      = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_NUM_ROWS;
    cfg_data   = '0;
    rows_used  = dim_in_use(DIM_RESET);
    cols_used  = dim_in_use(DIM_RESET);
    burst_left = 0;
    cycle_count = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       begin rows_val = 6'd4;  cols_val = 6'd5;  end
        1:       begin rows_val = 6'd32; cols_val = 6'd32; end
        2:       begin rows_val = 6'd0;  cols_val = 6'd63; end
        3:       begin rows_val = 6'd63; cols_val = 6'd0;  end
        4:       begin rows_val = 6'd7;  cols_val = 6'd3;  end
        5:       begin
          rows_val = $urandom_range(1, SIDE);
          cols_val = $urandom_range(1, SIDE);
        end
        6:       begin rows_val = 6'd2;  cols_val = 6'd31; end
        default: begin rows_val = 6'd32; cols_val = 6'd32; end
      endcase
      set_dims(rows_val, cols_val);

      // Directed items on a 4 by 5 matrix
      if (phase == 0) begin
        issue(ACT_WRITE, 0, 0, 32'h7FFF_FFFF, 1'b0, 16'hFFFF);
        issue(ACT_WRITE, 3, 4, 32'h8000_0000, 1'b1, 16'h0000);
        issue(ACT_WRITE, 0, 4, 32'hFFFF_FFFF, 1'b0, 16'h1234);
        issue(ACT_WRITE, 3, 0, 32'h0000_0000, 1'b1, 16'h0001);
        issue(ACT_WRITE, 0, 1, 32'd11, 1'b0, 16'd0);
        issue(ACT_WRITE, 0, 2, -32'sd22, 1'b0, 16'd0);
        issue(ACT_WRITE, 0, 3, 32'd33, 1'b0, 16'd0);
        issue(ACT_READ, 0, 0, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        issue(ACT_READ, 3, 4, 32'd0, 1'b0, 16'd0);
        // zero, a multiple of the length, and the largest amount
        issue(ACT_ROT_ROW, 0, 31, 32'd0, 1'b1, 16'd0);
        issue(ACT_ROT_ROW, 0, 9, 32'd0, 1'b1, 16'd5);
        issue(ACT_ROT_ROW, 0, 0, 32'd0, 1'b1, 16'hFFFF);
        issue(ACT_ROT_ROW, 0, 0, 32'd0, 1'b0, 16'd2);
        issue(ACT_ROT_ROW, 0, 0, 32'd0, 1'b1, 16'd1);
        issue(ACT_READ, 0, 0, 32'd0, 1'b0, 16'd0);
        issue(ACT_WRITE, 1, 0, 32'h1357_9BDF, 1'b0, 16'd0);
        issue(ACT_WRITE, 2, 0, 32'hECA8_6420, 1'b0, 16'd0);
        issue(ACT_ROT_COL, 31, 0, 32'd0, 1'b1, 16'd1);
        issue(ACT_ROT_COL, 0, 0, 32'd0, 1'b0, 16'd3);
        issue(ACT_READ, 3, 0, 32'd0, 1'b0, 16'd0);
        // indexes outside the dimensions in use
        issue(ACT_WRITE, 4, 0, 32'hDEAD_BEEF, 1'b0, 16'd0);
        issue(ACT_READ, 0, 5, 32'd0, 1'b0, 16'd0);
        issue(ACT_ROT_ROW, 31, 0, 32'd0, 1'b1, 16'd1);
        issue(ACT_ROT_COL, 0, 31, 32'd0, 1'b0, 16'd1);
        issue(ACT_READ, 31, 31, 32'd0, 1'b1, 16'd0);
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 59) == 0) wait_idle();
        random_item();
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("matrix_line_rotator verification clean");
    end else begin
      $display("matrix_line_rotator verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mlr_pkg.sv
hw/rtl/mlr_mod.sv
hw/rtl/mlr_datapath.sv
hw/rtl/mlr_ctrl.sv
hw/rtl/matrix_line_rotator.sv
bench/matrix_line_rotator_checker.sv
bench/tb_top.sv
